[rtl/lnds_pkg.sv]
// Package for the longest non-decreasing subsequence tracker.
// Capacity, widths and the tail memory word layout. No dependencies.
package lnds_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int VALUE_BITS = 16;

  // Tail position / item index width and chain length width.
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int LEN_W  = $clog2(MAX_ITEMS + 1);

  // One tail entry: smallest value ending a chain of a given length,
  // and the arrival index of the item that holds it.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [ADDR_W-1:0]     item;
  } tail_t;

  localparam int TAIL_W = $bits(tail_t);

endpackage

[rtl/longest_nondecreasing_subsequence.sv]
// Streaming longest non-decreasing subsequence tracker, tails-array method.
// Uses lnds_pkg and one lnds_ram instance holding the tail entries.
//
// Each accepted item gets an arrival index counted from zero since the last
// restart, and produces exactly one result item: the length of the best
// non-decreasing chain ending at it, the index of its predecessor in that
// chain (if any), the best length so far, its own index and an overflow flag.
// One item is handled at a time. An item that is beyond capacity, or that
// starts an empty sequence, goes straight to the emit state. Any other
// item first reads the last tail; if it extends the chain it goes on to
// the emit state, otherwise a binary search runs, one tail read per cycle
// through the registered-read tail RAM, until its tail position is found.
// in_stall is high from acceptance until the result is handed to the
// output register; a finished result may wait there while the next item
// is already accepted. The tail RAM needs no clearing: only entries below
// the current length are ever read.
module longest_nondecreasing_subsequence
  import lnds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_value,
  input  logic        in_restart,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_chain_length,
  output logic        out_has_predecessor,
  output logic [9:0]  out_predecessor_index,
  output logic [10:0] out_best_length,
  output logic [9:0]  out_item_index,
  output logic        out_overflow
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_LAST = 2'd1;  // last tail read in flight
  localparam logic [1:0] ST_SRCH = 2'd2;  // search probe read in flight
  localparam logic [1:0] ST_EMIT = 2'd3;  // write tail, hand off result

  logic [1:0]            state_r, state_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;      // current chain length
  logic [LEN_W-1:0]      cnt_r, cnt_nxt;      // items in this sequence
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]     lo_r, lo_nxt;
  logic [ADDR_W-1:0]     hi_r, hi_nxt;
  logic [ADDR_W-1:0]     mid_r, mid_nxt;
  logic [ADDR_W-1:0]     pos_r, pos_nxt;
  logic                  hasp_r, hasp_nxt;
  logic [ADDR_W-1:0]     pred_r, pred_nxt;

  // output register
  logic                  ov_r, ov_nxt;
  logic [10:0]           o_chain_r, o_chain_nxt;
  logic                  o_hasp_r, o_hasp_nxt;
  logic [9:0]            o_pred_r, o_pred_nxt;
  logic [10:0]           o_best_r, o_best_nxt;
  logic [9:0]            o_idx_r, o_idx_nxt;
  logic                  o_ovf_r, o_ovf_nxt;

  // tail RAM port
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  tail_t             wr_data;
  tail_t             rd_data;

  // combinational helpers
  logic              accept;
  logic              out_free;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  cnt_eff;
  logic [ADDR_W-1:0] lo_new;
  logic [ADDR_W-1:0] hi_new;
  logic [ADDR_W:0]   mid_sum;

  lnds_ram #(
    .WIDTH (TAIL_W),
    .DEPTH (MAX_ITEMS)
  ) u_tail_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;

  assign wr_data.value = val_r;
  assign wr_data.item  = idx_r;

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    val_nxt     = val_r;
    idx_nxt     = idx_r;
    ovf_nxt     = ovf_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    pos_nxt     = pos_r;
    hasp_nxt    = hasp_r;
    pred_nxt    = pred_r;
    ov_nxt      = ov_r && out_stall;
    o_chain_nxt = o_chain_r;
    o_hasp_nxt  = o_hasp_r;
    o_pred_nxt  = o_pred_r;
    o_best_nxt  = o_best_r;
    o_idx_nxt   = o_idx_r;
    o_ovf_nxt   = o_ovf_r;
    wr_en       = 1'b0;
    rd_addr     = mid_r;
    len_eff     = in_restart ? '0 : len_r;
    cnt_eff     = in_restart ? '0 : cnt_r;
    lo_new      = lo_r;
    hi_new      = hi_r;
    mid_sum     = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt  = in_value[VALUE_BITS-1:0];
          len_nxt  = len_eff;
          hasp_nxt = 1'b0;
          pred_nxt = '0;
          pos_nxt  = '0;
          if (cnt_eff >= LEN_W'(MAX_ITEMS)) begin
            // beyond capacity: item ignored, state untouched
            ovf_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            ovf_nxt = 1'b0;
            idx_nxt = cnt_eff[ADDR_W-1:0];
            cnt_nxt = cnt_eff + LEN_W'(1);
            if (len_eff == '0) begin
              len_nxt   = LEN_W'(1);
              state_nxt = ST_EMIT;
            end else begin
              rd_addr   = ADDR_W'(len_eff - LEN_W'(1));
              state_nxt = ST_LAST;
            end
          end
        end
      end

      ST_LAST: begin
        if (val_r >= rd_data.value) begin
          // extend the chain past the last tail
          pos_nxt   = len_r[ADDR_W-1:0];
          hasp_nxt  = 1'b1;
          pred_nxt  = rd_data.item;
          len_nxt   = len_r + LEN_W'(1);
          state_nxt = ST_EMIT;
        end else if (len_r == LEN_W'(1)) begin
          pos_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = ADDR_W'(len_r - LEN_W'(1));
          mid_sum   = {1'b0, hi_nxt};
          mid_nxt   = mid_sum[ADDR_W:1];
          rd_addr   = mid_nxt;
          state_nxt = ST_SRCH;
        end
      end

      ST_SRCH: begin
        // strictly greater tail narrows from above; equal passes over
        if (rd_data.value > val_r) begin
          hi_new = mid_r;
        end else begin
          lo_new   = mid_r + ADDR_W'(1);
          hasp_nxt = 1'b1;
          pred_nxt = rd_data.item;   // tail just below the new lo
        end
        lo_nxt = lo_new;
        hi_nxt = hi_new;
        if (lo_new == hi_new) begin
          pos_nxt   = lo_new;
          state_nxt = ST_EMIT;
        end else begin
          mid_sum   = {1'b0, lo_new} + {1'b0, hi_new};
          mid_nxt   = mid_sum[ADDR_W:1];
          rd_addr   = mid_nxt;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          wr_en  = !ovf_r;
          ov_nxt = 1'b1;
          if (ovf_r) begin
            o_chain_nxt = '0;
            o_hasp_nxt  = 1'b0;
            o_pred_nxt  = '0;
            o_idx_nxt   = '0;
          end else begin
            o_chain_nxt = 11'({1'b0, pos_r} + 11'd1);
            o_hasp_nxt  = hasp_r;
            o_pred_nxt  = 10'(pred_r);
            o_idx_nxt   = 10'(idx_r);
          end
          o_best_nxt = 11'(len_r);
          o_ovf_nxt  = ovf_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    ovf_r     <= ovf_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    pos_r     <= pos_nxt;
    hasp_r    <= hasp_nxt;
    pred_r    <= pred_nxt;
    o_chain_r <= o_chain_nxt;
    o_hasp_r  <= o_hasp_nxt;
    o_pred_r  <= o_pred_nxt;
    o_best_r  <= o_best_nxt;
    o_idx_r   <= o_idx_nxt;
    o_ovf_r   <= o_ovf_nxt;
  end

  assign out_valid             = ov_r;
  assign out_chain_length      = o_chain_r;
  assign out_has_predecessor   = o_hasp_r;
  assign out_predecessor_index = o_pred_r;
  assign out_best_length       = o_best_r;
  assign out_item_index        = o_idx_r;
  assign out_overflow          = o_ovf_r;

endmodule

[rtl/lnds_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; width and depth set by parameters.
module lnds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
